// File: design/dge_pkg.sv
// Shared types, constants and helper functions of the grid explorer.
package dge_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int COORD_W    = 6;
    localparam int SIDE_W     = 7;
    localparam int DIR_W      = 2;
    localparam int TRY_W      = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [DIR_W-1:0]    dir_t;
    typedef logic [MAX_SIDE-1:0] map_row_t;
    typedef logic [IN_USER_W-1:0] op_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_ROW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_COL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE      = 2'd2;

    localparam op_t OP_START = 2'd0;
    localparam op_t OP_REPLY = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_LEFT  = 2'd1;
    localparam dir_t DIR_DOWN  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    // One path cell: position, next direction to try (0..4), arrival direction.
    typedef struct packed {
        coord_t             row;
        coord_t             col;
        logic [TRY_W-1:0]   try_dir;
        dir_t               arr_dir;
    } stack_entry_t;

    typedef struct packed {
        logic [2:0] pad;
        coord_t     read_col;
        coord_t     read_row;
        logic       move_ok;
    } in_data_t;

    typedef struct packed {
        logic [5:0] pad;
        coord_t     walker_col;
        coord_t     walker_row;
        logic       cell_blocked;
        logic       explore_done;
        logic       is_backtrack;
        dir_t       move_dir;
        logic       move_request;
    } out_data_t;

    // A side of zero acts as one, and one above the map size acts as the map size.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
        if (side == '0) begin
            return SIDE_W'(1);
        end
        else if (side > SIDE_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return side;
    endfunction

endpackage

// File: design/dge_map_ram.sv
// Visited map storage: one word per grid row, one bit per column.
module dge_map_ram (
    input  logic             clk,
    input  logic             rd_en,
    input  dge_pkg::coord_t  rd_addr,
    output dge_pkg::map_row_t rd_data,
    input  logic             wr_en,
    input  dge_pkg::coord_t  wr_addr,
    input  dge_pkg::map_row_t wr_data
);
    import dge_pkg::*;

    map_row_t mem [MAX_SIDE];
    map_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dge_stack_ram.sv
// Path stack storage: one entry per cell on the search path below the cached top.
module dge_stack_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output dge_pkg::stack_entry_t       rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  dge_pkg::stack_entry_t       wr_data
);
    import dge_pkg::*;

    stack_entry_t mem [DEPTH];
    stack_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dfs_grid_explorer_core.sv
// Depth-first grid explorer: sequencer around the visited map and the path stack.
//
// Items enter on the s_axis channel (tuser = op, tdata = reply flag and read
// address) and each one yields exactly one result on the m_axis channel.
// Configuration (start cell, side) is written through cfg_wr_en/cfg_addr/
// cfg_wr_data while no item is in flight.
// A reply item's result is loaded after these steps: a step, after a confirmed
// move, that marks a newly reached cell in the map and pushes the old top, three
// map reads for the rows above, at and below the top cell (the map has a
// single read port), a decision step, one stack read when the top cell is
// popped, and the output load. A read item's result is loaded after a single
// map read; a reply with an empty stack or an unused op goes straight to the load.
// A start item first clears the map one row per cycle, then marks the start
// cell and runs the three map reads and the decision step. The next item is
// accepted as soon as a result is loaded.
// After reset the same clearing pass runs before s_axis_tready rises.
// The result sits in an output register; the next item is accepted while it
// waits, and if m_axis_tready stays low the block holds in its emit step
// until the register is free, so no result is lost.
module dfs_grid_explorer_core #(
    parameter int STACK_DEPTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // move_ok[0], read_row[6:1], read_col[12:7], zeros[15:13]
    input  logic [dge_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // op[1:0]
    input  logic [dge_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // move_request[0], move_dir[2:1], is_backtrack[3], explore_done[4],
    // cell_blocked[5], walker_row[11:6], walker_col[17:12], zeros[23:18]
    output logic [dge_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [dge_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [dge_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import dge_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_ROOT   = 11'b000_0000_0100,
        ST_MARK   = 11'b000_0000_1000,
        ST_NB_UP  = 11'b000_0001_0000,
        ST_NB_MID = 11'b000_0010_0000,
        ST_NB_DN  = 11'b000_0100_0000,
        ST_DECIDE = 11'b000_1000_0000,
        ST_POP    = 11'b001_0000_0000,
        ST_CELL   = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    coord_t               clr_row_reg;
    logic                 clr_start_reg;
    coord_t               start_row_reg, start_col_reg;
    logic [SIDE_W-1:0]    side_reg;
    logic [CNT_W-1:0]     count_reg;
    dir_t                 pending_dir_reg;
    logic                 pending_back_reg;
    logic                 finished_reg;
    logic                 m_valid_reg;

    coord_t               top_row_reg, top_col_reg;
    logic [TRY_W-1:0]     top_try_reg;
    dir_t                 top_arr_reg;
    coord_t               cand_row_reg, cand_col_reg;
    map_row_t             up_row_reg, mid_row_reg;
    logic                 res_req_reg, res_back_reg, res_blocked_reg;
    dir_t                 res_dir_reg;
    out_data_t            m_data_reg;

    logic                 map_rd_en, map_wr_en;
    coord_t               map_rd_addr, map_wr_addr;
    map_row_t             map_rd_data, map_wr_data;
    logic                 stk_rd_en, stk_wr_en;
    logic [AW-1:0]        stk_rd_addr, stk_wr_addr;
    stack_entry_t         stk_rd_data, stk_wr_data;

    in_data_t             in_data;
    op_t                  op;
    logic                 in_fire, out_free;
    logic [SIDE_W-1:0]    s_eff;
    logic                 room;
    logic [CNT_W-1:0]     cnt_m1, cnt_m2;
    logic                 push_ok;
    coord_t               push_row, push_col;
    coord_t               root_row, root_col;
    logic [SIDE_W-1:0]    s_m1;
    coord_t               col_left, col_right;
    logic [3:0]           free_dir;
    logic                 found;
    dir_t                 found_dir, back_dir;
    logic                 cell_blocked;
    out_data_t            out_word;

    // Neighbour of (r,c) in direction d lies inside an s-by-s grid.
    function automatic logic nb_valid(input coord_t r, input coord_t c, input dir_t d,
                                      input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r_ext;
        logic [SIDE_W-1:0] c_ext;
        logic              ok;
        r_ext = {1'b0, r};
        c_ext = {1'b0, c};
        ok = (r_ext < s) && (c_ext < s);
        case (d)
            DIR_UP:   ok = ok && (r != '0);
            DIR_LEFT: ok = ok && (c != '0);
            DIR_DOWN: ok = ok && ((r_ext + SIDE_W'(1)) < s);
            default:  ok = ok && ((c_ext + SIDE_W'(1)) < s);
        endcase
        return ok;
    endfunction

    function automatic coord_t nb_row(input coord_t r, input dir_t d);
        coord_t n;
        case (d)
            DIR_UP:   n = r - coord_t'(1);
            DIR_DOWN: n = r + coord_t'(1);
            default:  n = r;
        endcase
        return n;
    endfunction

    function automatic coord_t nb_col(input coord_t c, input dir_t d);
        coord_t n;
        case (d)
            DIR_LEFT:  n = c - coord_t'(1);
            DIR_RIGHT: n = c + coord_t'(1);
            default:   n = c;
        endcase
        return n;
    endfunction

    assign in_data       = in_data_t'(s_axis_tdata);
    assign op            = s_axis_tuser;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_eff         = eff_side(side_reg);
    assign room          = (count_reg < CNT_W'(STACK_DEPTH));
    assign cnt_m1        = count_reg - CNT_W'(1);
    assign cnt_m2        = count_reg - CNT_W'(2);

    // Forward move just confirmed by the walker.
    assign push_ok  = in_data.move_ok && room
                   && nb_valid(top_row_reg, top_col_reg, pending_dir_reg, s_eff);
    assign push_row = nb_row(top_row_reg, pending_dir_reg);
    assign push_col = nb_col(top_col_reg, pending_dir_reg);

    assign s_m1     = s_eff - SIDE_W'(1);
    assign root_row = ({1'b0, start_row_reg} < s_eff) ? start_row_reg : s_m1[COORD_W-1:0];
    assign root_col = ({1'b0, start_col_reg} < s_eff) ? start_col_reg : s_m1[COORD_W-1:0];

    // Candidate directions from the top cell; the row below arrives straight
    // from the map read port in the decision cycle.
    assign col_left  = top_col_reg - coord_t'(1);
    assign col_right = top_col_reg + coord_t'(1);

    always_comb
    begin
        free_dir[0] = ({1'b0, DIR_UP} >= top_try_reg)
                   && nb_valid(top_row_reg, top_col_reg, DIR_UP, s_eff)
                   && !up_row_reg[top_col_reg];
        free_dir[1] = ({1'b0, DIR_LEFT} >= top_try_reg)
                   && nb_valid(top_row_reg, top_col_reg, DIR_LEFT, s_eff)
                   && !mid_row_reg[col_left];
        free_dir[2] = ({1'b0, DIR_DOWN} >= top_try_reg)
                   && nb_valid(top_row_reg, top_col_reg, DIR_DOWN, s_eff)
                   && !map_rd_data[top_col_reg];
        free_dir[3] = ({1'b0, DIR_RIGHT} >= top_try_reg)
                   && nb_valid(top_row_reg, top_col_reg, DIR_RIGHT, s_eff)
                   && !mid_row_reg[col_right];
        found = room && (free_dir != '0);
        if (free_dir[0])
        begin
            found_dir = DIR_UP;
        end
        else if (free_dir[1])
        begin
            found_dir = DIR_LEFT;
        end
        else if (free_dir[2])
        begin
            found_dir = DIR_DOWN;
        end
        else
        begin
            found_dir = DIR_RIGHT;
        end
    end

    assign back_dir     = top_arr_reg + DIR_W'(2);
    assign cell_blocked = !(({1'b0, cand_row_reg} < s_eff) && ({1'b0, cand_col_reg} < s_eff)
                            && map_rd_data[cand_col_reg]);

    always_comb
    begin
        out_word              = '0;
        out_word.move_request = res_req_reg;
        out_word.move_dir     = res_dir_reg;
        out_word.is_backtrack = res_back_reg;
        out_word.explore_done = finished_reg;
        out_word.cell_blocked = res_blocked_reg;
        if (count_reg != '0)
        begin
            out_word.walker_row = top_row_reg;
            out_word.walker_col = top_col_reg;
        end
    end

    // Memory port control.
    always_comb
    begin
        map_rd_en   = 1'b0;
        map_rd_addr = top_row_reg;
        map_wr_en   = 1'b0;
        map_wr_addr = cand_row_reg;
        map_wr_data = map_rd_data | (map_row_t'(1) << cand_col_reg);
        stk_rd_en   = 1'b0;
        stk_rd_addr = cnt_m2[AW-1:0];
        stk_wr_en   = 1'b0;
        stk_wr_addr = cnt_m1[AW-1:0];
        stk_wr_data = '{row: top_row_reg, col: top_col_reg,
                        try_dir: top_try_reg, arr_dir: top_arr_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = clr_row_reg;
                map_wr_data = '0;
            end
            ST_IDLE:
            begin
                if (in_fire && (op == OP_READ))
                begin
                    map_rd_en   = 1'b1;
                    map_rd_addr = in_data.read_row;
                end
                else if (in_fire && (op == OP_REPLY) && (count_reg != '0)
                         && !pending_back_reg && push_ok)
                begin
                    map_rd_en   = 1'b1;
                    map_rd_addr = push_row;
                end
            end
            ST_ROOT:
            begin
                map_wr_en   = 1'b1;
                map_wr_addr = root_row;
                map_wr_data = map_row_t'(1) << root_col;
            end
            ST_MARK:
            begin
                map_wr_en = 1'b1;
                stk_wr_en = 1'b1;
            end
            ST_NB_UP:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = top_row_reg - coord_t'(1);
            end
            ST_NB_MID:
            begin
                map_rd_en = 1'b1;
            end
            ST_NB_DN:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = top_row_reg + coord_t'(1);
            end
            ST_DECIDE:
            begin
                stk_rd_en = !found && (count_reg > CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == coord_t'(MAX_SIDE - 1))
                begin
                    state_next = clr_start_reg ? ST_ROOT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_START: state_next = ST_CLEAR;
                        OP_REPLY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_EMIT;
                            end
                            else if (pending_back_reg || !push_ok)
                            begin
                                state_next = ST_NB_UP;
                            end
                            else
                            begin
                                state_next = ST_MARK;
                            end
                        end
                        OP_READ:  state_next = ST_CELL;
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_ROOT:   state_next = ST_NB_UP;
            ST_MARK:   state_next = ST_NB_UP;
            ST_NB_UP:  state_next = ST_NB_MID;
            ST_NB_MID: state_next = ST_NB_DN;
            ST_NB_DN:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!found && (count_reg > CNT_W'(1)))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_POP:    state_next = ST_EMIT;
            ST_CELL:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_row_reg      <= '0;
            clr_start_reg    <= 1'b0;
            start_row_reg    <= '0;
            start_col_reg    <= '0;
            side_reg         <= SIDE_W'(MAX_SIDE);
            count_reg        <= '0;
            pending_dir_reg  <= DIR_UP;
            pending_back_reg <= 1'b0;
            finished_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_START_ROW: start_row_reg <= cfg_wr_data[COORD_W-1:0];
                    CFG_START_COL: start_col_reg <= cfg_wr_data[COORD_W-1:0];
                    CFG_SIDE:      side_reg      <= cfg_wr_data;
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + coord_t'(1);
                end
                ST_IDLE:
                begin
                    if (in_fire && (op == OP_START))
                    begin
                        clr_row_reg   <= '0;
                        clr_start_reg <= 1'b1;
                    end
                end
                ST_ROOT:
                begin
                    clr_start_reg    <= 1'b0;
                    count_reg        <= CNT_W'(1);
                    finished_reg     <= 1'b0;
                    pending_dir_reg  <= DIR_UP;
                    pending_back_reg <= 1'b0;
                end
                ST_MARK:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                ST_DECIDE:
                begin
                    if (found)
                    begin
                        pending_dir_reg  <= found_dir;
                        pending_back_reg <= 1'b0;
                    end
                    else
                    begin
                        count_reg <= cnt_m1;
                        if (count_reg > CNT_W'(1))
                        begin
                            pending_dir_reg  <= back_dir;
                            pending_back_reg <= 1'b1;
                        end
                        else
                        begin
                            finished_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_req_reg     <= 1'b0;
                    res_dir_reg     <= DIR_UP;
                    res_back_reg    <= 1'b0;
                    res_blocked_reg <= 1'b0;
                    if (op == OP_READ)
                    begin
                        cand_row_reg <= in_data.read_row;
                        cand_col_reg <= in_data.read_col;
                    end
                    else
                    begin
                        cand_row_reg <= push_row;
                        cand_col_reg <= push_col;
                    end
                    // The tried direction is consumed by any forward reply.
                    if ((op == OP_REPLY) && (count_reg != '0) && !pending_back_reg)
                    begin
                        top_try_reg <= {1'b0, pending_dir_reg} + TRY_W'(1);
                    end
                end
            end
            ST_ROOT:
            begin
                top_row_reg <= root_row;
                top_col_reg <= root_col;
                top_try_reg <= '0;
                top_arr_reg <= DIR_UP;
            end
            ST_MARK:
            begin
                top_row_reg <= cand_row_reg;
                top_col_reg <= cand_col_reg;
                top_try_reg <= '0;
                top_arr_reg <= pending_dir_reg;
            end
            ST_NB_MID:
            begin
                up_row_reg <= map_rd_data;
            end
            ST_NB_DN:
            begin
                mid_row_reg <= map_rd_data;
            end
            ST_DECIDE:
            begin
                if (found)
                begin
                    res_req_reg <= 1'b1;
                    res_dir_reg <= found_dir;
                end
                else if (count_reg > CNT_W'(1))
                begin
                    res_req_reg  <= 1'b1;
                    res_dir_reg  <= back_dir;
                    res_back_reg <= 1'b1;
                end
            end
            ST_POP:
            begin
                top_row_reg <= stk_rd_data.row;
                top_col_reg <= stk_rd_data.col;
                top_try_reg <= stk_rd_data.try_dir;
                top_arr_reg <= stk_rd_data.arr_dir;
            end
            ST_CELL:
            begin
                res_blocked_reg <= cell_blocked;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_data_reg <= out_word;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    dge_map_ram u_map_ram (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    dge_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data)
    );

endmodule

// File: design/dge_core_checker.sv
// Port-level checks on the grid explorer's result channel, bound to the top level.
module dge_core_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dge_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import dge_pkg::*;

    out_data_t od;

    assign od = out_data_t'(m_axis_tdata);

    // A stalled result holds its contents until the transfer.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Without a move request there is neither a direction nor a backtrack.
    a_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !od.move_request |-> (od.move_dir == DIR_UP) && !od.is_backtrack)
        else $error("direction or backtrack without a move request");

    // A map read never asks for a move: a blocked cell comes without a move request.
    a_read_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && od.cell_blocked |-> !od.move_request)
        else $error("blocked cell reported together with a move");

    // Once exploration is done the stack is empty: no move and a zero walker.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && od.explore_done
            |-> !od.move_request && (od.walker_row == '0) && (od.walker_col == '0))
        else $error("done flag with a live walker position");

endmodule

bind dfs_grid_explorer_core dge_core_checker u_dge_core_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
